// ----- rtl/tcc_pkg.sv -----
`default_nettype none

package tcc_pkg;

	// item kinds carried in s_axis_tuser
	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_SET  = 2'd1,
		FUNC_LOAD = 2'd2
	} func_t;

	localparam int unsigned TICK_W  = 7;
	localparam int unsigned HUND_W  = 7;
	localparam int unsigned SEC_W   = 6;
	localparam int unsigned MIN_W   = 6;
	localparam int unsigned HOUR_W  = 5;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 7;
	localparam int unsigned CNT_W   = 16;

	localparam logic [TICK_W-1:0] TICK_MAX  = 7'd99;
	localparam logic [HUND_W:0]   HUND_MOD  = 8'd100;
	localparam logic [SEC_W:0]    SEC_MOD   = 7'd60;
	localparam logic [MIN_W:0]    MIN_MOD   = 7'd60;
	localparam logic [HOUR_W:0]   HOUR_MOD  = 6'd24;
	localparam logic [MONTH_W:0]  MONTH_MOD = 5'd13;
	localparam logic [YEAR_W:0]   YEAR_MOD  = 8'd100;
	localparam logic [CNT_W-1:0]  CNT_MAX   = 16'hFFFF;

	typedef struct packed {
		logic [1:0]         func;
		logic [TICK_W-1:0]  elapsed_ticks;
		logic [YEAR_W-1:0]  set_year;
		logic [MONTH_W-1:0] set_month;
		logic [DAY_W-1:0]   set_day;
		logic [HOUR_W-1:0]  set_hour;
		logic [MIN_W-1:0]   set_minute;
		logic [SEC_W-1:0]   set_second;
		logic [CNT_W-1:0]   timeout_value;
	} item_t;

	typedef struct packed {
		logic               second_event;
		logic [SEC_W-1:0]   out_second;
		logic [MIN_W-1:0]   out_minute;
		logic [HOUR_W-1:0]  out_hour;
		logic [DAY_W-1:0]   out_day;
		logic [MONTH_W-1:0] out_month;
		logic [YEAR_W-1:0]  out_year;
		logic [CNT_W-1:0]   timeout_left;
		logic [CNT_W-1:0]   passes_per_second;
	} result_t;

	// day value at which the month rolls over (days in month plus one)
	function automatic logic [DAY_W:0] day_limit(input logic [MONTH_W-1:0] month,
		input logic [YEAR_W-1:0] year);
		logic [DAY_W:0] lim;
		lim = 6'd32;
		unique case (month)
			4'd2:                      lim = (year[1:0] != 2'd0) ? 6'd29 : 6'd30;
			4'd4, 4'd6, 4'd9, 4'd11:   lim = 6'd31;
			default:                   lim = 6'd32;
		endcase
		return lim;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/tcc_in_stage.sv -----
`default_nettype none

module tcc_in_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire tcc_pkg::item_t in_item,
	input  wire logic          take,
	output logic               valid_s1,
	output tcc_pkg::item_t     item_s1
);
	import tcc_pkg::*;

	// stage frees up when empty or when its transaction moves on this cycle
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/tcc_core.sv -----
`default_nettype none

module tcc_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire tcc_pkg::item_t item,
	output tcc_pkg::result_t    res
);
	import tcc_pkg::*;

	logic [HUND_W-1:0]  hund_q, hund_d;
	logic [SEC_W-1:0]   sec_q, sec_d;
	logic [MIN_W-1:0]   min_q, min_d;
	logic [HOUR_W-1:0]  hour_q, hour_d;
	logic [DAY_W-1:0]   day_q, day_d;
	logic [MONTH_W-1:0] month_q, month_d;
	logic [YEAR_W-1:0]  year_q, year_d;
	logic [CNT_W-1:0]   tmo_q, tmo_d;
	logic [CNT_W-1:0]   pass_q, pass_d;
	logic [CNT_W-1:0]   rate_q, rate_d;
	logic               event_q, event_d;

	logic [TICK_W-1:0]  ticks;
	logic [HUND_W:0]    sum;
	logic               is_tick;
	logic [SEC_W:0]     sec_inc;
	logic [MIN_W:0]     min_inc;
	logic [HOUR_W:0]    hour_inc;
	logic [DAY_W:0]     day_inc;
	logic [MONTH_W:0]   month_inc;
	logic [YEAR_W:0]    year_inc;
	logic               c_min, c_hour, c_day, c_month, c_year;
	logic [CNT_W-1:0]   pass_base;

	always_comb begin
		is_tick   = (item.func == FUNC_TICK);
		ticks     = (item.elapsed_ticks > TICK_MAX) ? TICK_MAX : item.elapsed_ticks;
		sum       = {1'b0, hund_q} + {1'b0, ticks};
		event_d   = is_tick && (sum >= HUND_MOD);

		sec_inc   = {1'b0, sec_q} + 7'd1;
		min_inc   = {1'b0, min_q} + 7'd1;
		hour_inc  = {1'b0, hour_q} + 6'd1;
		day_inc   = {1'b0, day_q} + 6'd1;
		month_inc = {1'b0, month_q} + 5'd1;
		year_inc  = {1'b0, year_q} + 8'd1;

		// ripple of rollovers, only on a second event
		c_min   = event_d && (sec_inc >= SEC_MOD);
		c_hour  = c_min && (min_inc >= MIN_MOD);
		c_day   = c_hour && (hour_inc >= HOUR_MOD);
		c_month = c_day && (day_inc >= day_limit(month_q, year_q));
		c_year  = c_month && (month_inc >= MONTH_MOD);

		hund_d  = hund_q;
		sec_d   = sec_q;
		min_d   = min_q;
		hour_d  = hour_q;
		day_d   = day_q;
		month_d = month_q;
		year_d  = year_q;
		tmo_d   = tmo_q;
		pass_d  = pass_q;
		rate_d  = rate_q;
		pass_base = pass_q;

		unique case (item.func)
			FUNC_TICK: begin
				if (event_d) begin
					hund_d = sum[HUND_W-1:0] - HUND_MOD[HUND_W-1:0];
					if (tmo_q != '0) begin
						tmo_d = tmo_q - 16'd1;
					end
					rate_d    = pass_q;
					pass_base = '0;
					sec_d = c_min ? '0 : sec_inc[SEC_W-1:0];
				end else begin
					hund_d = sum[HUND_W-1:0];
				end
				if (c_min) begin
					min_d = c_hour ? '0 : min_inc[MIN_W-1:0];
				end
				if (c_hour) begin
					hour_d = c_day ? '0 : hour_inc[HOUR_W-1:0];
				end
				if (c_day) begin
					day_d = c_month ? 5'd1 : day_inc[DAY_W-1:0];
				end
				if (c_month) begin
					month_d = c_year ? 4'd1 : month_inc[MONTH_W-1:0];
				end
				if (c_year) begin
					year_d = (year_inc >= YEAR_MOD) ? '0 : year_inc[YEAR_W-1:0];
				end
				pass_d = (pass_base == CNT_MAX) ? pass_base : pass_base + 16'd1;
			end
			FUNC_SET: begin
				year_d  = item.set_year;
				month_d = item.set_month;
				day_d   = item.set_day;
				hour_d  = item.set_hour;
				min_d   = item.set_minute;
				sec_d   = item.set_second;
			end
			FUNC_LOAD: begin
				tmo_d = item.timeout_value;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hund_q  <= '0;
			sec_q   <= '0;
			min_q   <= '0;
			hour_q  <= '0;
			day_q   <= 5'd1;
			month_q <= 4'd1;
			year_q  <= '0;
			tmo_q   <= '0;
			pass_q  <= '0;
			rate_q  <= '0;
			event_q <= 1'b0;
		end else if (step) begin
			hund_q  <= hund_d;
			sec_q   <= sec_d;
			min_q   <= min_d;
			hour_q  <= hour_d;
			day_q   <= day_d;
			month_q <= month_d;
			year_q  <= year_d;
			tmo_q   <= tmo_d;
			pass_q  <= pass_d;
			rate_q  <= rate_d;
			event_q <= event_d;
		end
	end

	// state registers double as the result register
	assign res.second_event      = event_q;
	assign res.out_second        = sec_q;
	assign res.out_minute        = min_q;
	assign res.out_hour          = hour_q;
	assign res.out_day           = day_q;
	assign res.out_month         = month_q;
	assign res.out_year          = year_q;
	assign res.timeout_left      = tmo_q;
	assign res.passes_per_second = rate_q;

endmodule

`default_nettype wire

// ----- rtl/tick_clock_calendar_top.sv -----
`default_nettype none

// Channel  | Dir | Signals              | Contents
// ---------+-----+----------------------+----------------------------------------------
// s_axis   | in  | tvalid/tready/tuser  | tuser: func; tdata: set/tick/load payload
//          |     | tdata[55:0]          |
// m_axis   | out | tvalid/tready/tuser  | tuser: second_event; tdata: calendar + counters
//          |     | tdata[71:0]          |
//
// One transaction in per clock while m_axis_tready is high, one result out per
// transaction; an accepted input passes the input register, then the state/result register.
// All work happens in one combinational pass between the input register and
// the state registers, which also serve as the result register.
// Reset: asynchronous, active low; calendar comes up at day 1, month 1, year 0,
// 00:00:00 with timeout and pass counters cleared.
// Stalls: s_axis_tready falls only when both the input register and the result
// register are full and m_axis_tready is low; it depends combinationally on
// m_axis_tready.

module tick_clock_calendar_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [1:0] func
	input  wire logic [1:0]  s_axis_tuser,
	// [6:0] elapsed_ticks, [13:7] set_year, [17:14] set_month, [22:18] set_day,
	// [27:23] set_hour, [33:28] set_minute, [39:34] set_second,
	// [55:40] timeout_value
	input  wire logic [55:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [0] second_event
	output logic [0:0]       m_axis_tuser,
	// [5:0] out_second, [11:6] out_minute, [16:12] out_hour, [21:17] out_day,
	// [25:22] out_month, [32:26] out_year, [48:33] timeout_left,
	// [64:49] passes_per_second, [71:65] zero
	output logic [71:0]      m_axis_tdata
);
	import tcc_pkg::*;

	item_t   in_item;
	item_t   item_s1;
	result_t res;
	logic    valid_s1;
	logic    take;
	logic    out_valid_q;

	// unpack the slave-side transaction
	assign in_item.func          = s_axis_tuser;
	assign in_item.elapsed_ticks = s_axis_tdata[6:0];
	assign in_item.set_year      = s_axis_tdata[13:7];
	assign in_item.set_month     = s_axis_tdata[17:14];
	assign in_item.set_day       = s_axis_tdata[22:18];
	assign in_item.set_hour      = s_axis_tdata[27:23];
	assign in_item.set_minute    = s_axis_tdata[33:28];
	assign in_item.set_second    = s_axis_tdata[39:34];
	assign in_item.timeout_value = s_axis_tdata[55:40];

	// an item moves into the state/result register when that slot is free
	assign take = valid_s1 && (!out_valid_q || m_axis_tready);

	tcc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	tcc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (take),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = res.second_event;
	assign m_axis_tdata  = {7'd0,
		res.passes_per_second,
		res.timeout_left,
		res.out_year,
		res.out_month,
		res.out_day,
		res.out_hour,
		res.out_minute,
		res.out_second};

endmodule

`default_nettype wire

// ----- dv/tick_clock_calendar_top_tb.sv -----
`timescale 1ns / 1ps

module tick_clock_calendar_top_tb;
	import tcc_pkg::*;

	// func code 3 has no meaning; the block must just report its state
	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam int RAND_ITEMS = 1375;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [1:0]  s_axis_tuser  = '0;
	logic [55:0] s_axis_tdata  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [0:0]  m_axis_tuser;
	logic [71:0] m_axis_tdata;

	// percent of cycles in which either side holds off; zero during the calm stretch
	int idle_pct = 7;
	int n_errors = 0;

	// Predicted clock state, starting at its reset value.
	int hund_acc   = 0;
	int cal_sec    = 0;
	int cal_min    = 0;
	int cal_hour   = 0;
	int cal_day    = 1;
	int cal_month  = 1;
	int cal_year   = 0;
	int link_timer = 0;
	int pass_cnt   = 0;
	int pass_rate  = 0;

	// readouts still owed by the block, oldest first
	result_t readout_q[$];

	// one row of the directed plan; typed rows carry a hand-written readout
	typedef struct {
		item_t   it;
		bit      typed;
		result_t want;
	} row_t;

	row_t plan[25];

	tick_clock_calendar_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tdata (m_axis_tdata)
	);

	always #1 clk = ~clk;

	// Day value at which a month rolls over. Invalid months get 31 days.
	function automatic int month_end(int month, int year);
		case (month)
			2:          return (year % 4 != 0) ? 29 : 30;
			4, 6, 9, 11: return 31;
			default:    return 32;
		endcase
	endfunction

	// Ripple one second through the calendar; out-of-range fields wrap on the
	// first increment and carry on.
	task automatic roll_calendar();
		if (cal_sec + 1 < 60) begin
			cal_sec++;
			return;
		end
		cal_sec = 0;
		if (cal_min + 1 < 60) begin
			cal_min++;
			return;
		end
		cal_min = 0;
		if (cal_hour + 1 < 24) begin
			cal_hour++;
			return;
		end
		cal_hour = 0;
		if (cal_day + 1 < month_end(cal_month, cal_year)) begin
			cal_day++;
			return;
		end
		cal_day = 1;
		if (cal_month + 1 < 13) begin
			cal_month++;
			return;
		end
		cal_month = 1;
		cal_year  = (cal_year + 1 < 100) ? cal_year + 1 : 0;
	endtask

	// Apply one accepted transaction to the predicted state and return the readout.
	task automatic predict_readout(input item_t it, output result_t r);
		int ticks;
		bit tick_sec;
		tick_sec = 1'b0;
		if (it.func == FUNC_TICK) begin
			ticks = int'(it.elapsed_ticks);
			if (ticks > 99)
				ticks = 99;
			if (ticks != 0) begin
				hund_acc += ticks;
				if (hund_acc >= 100) begin
					hund_acc -= 100;
					tick_sec  = 1'b1;
					if (link_timer > 0)
						link_timer--;
					pass_rate = pass_cnt;
					pass_cnt  = 0;
					roll_calendar();
				end
			end
			// saturating pass counter, counted after the second is handled
			if (pass_cnt < 65535)
				pass_cnt++;
		end else if (it.func == FUNC_SET) begin
			cal_year  = int'(it.set_year);
			cal_month = int'(it.set_month);
			cal_day   = int'(it.set_day);
			cal_hour  = int'(it.set_hour);
			cal_min   = int'(it.set_minute);
			cal_sec   = int'(it.set_second);
		end else if (it.func == FUNC_LOAD) begin
			link_timer = int'(it.timeout_value);
		end
		r.second_event      = tick_sec;
		r.out_second        = 6'(cal_sec);
		r.out_minute        = 6'(cal_min);
		r.out_hour          = 5'(cal_hour);
		r.out_day           = 5'(cal_day);
		r.out_month         = 4'(cal_month);
		r.out_year          = 7'(cal_year);
		r.timeout_left      = 16'(link_timer);
		r.passes_per_second = 16'(pass_rate);
	endtask

	// random filler for the fields a given func ignores
	function automatic item_t noise();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return item_t'(raw[$bits(item_t)-1:0]);
	endfunction

	function automatic item_t mk_tick(int ticks);
		item_t it;
		it               = noise();
		it.func          = FUNC_TICK;
		it.elapsed_ticks = 7'(ticks);
		return it;
	endfunction

	function automatic item_t mk_set(int y, int mo, int d, int h, int mi, int s);
		item_t it;
		it            = noise();
		it.func       = FUNC_SET;
		it.set_year   = 7'(y);
		it.set_month  = 4'(mo);
		it.set_day    = 5'(d);
		it.set_hour   = 5'(h);
		it.set_minute = 6'(mi);
		it.set_second = 6'(s);
		return it;
	endfunction

	function automatic item_t mk_load(int v);
		item_t it;
		it               = noise();
		it.func          = FUNC_LOAD;
		it.timeout_value = 16'(v);
		return it;
	endfunction

	function automatic item_t mk_none();
		item_t it;
		it      = noise();
		it.func = FUNC_NONE;
		return it;
	endfunction

	function automatic result_t mk_res(bit ev, int s, int mi, int h, int d, int mo, int y,
		int tmo, int pps);
		result_t r;
		r.second_event      = ev;
		r.out_second        = 6'(s);
		r.out_minute        = 6'(mi);
		r.out_hour          = 5'(h);
		r.out_day           = 5'(d);
		r.out_month         = 4'(mo);
		r.out_year          = 7'(y);
		r.timeout_left      = 16'(tmo);
		r.passes_per_second = 16'(pps);
		return r;
	endfunction

	// Random traffic: mostly tick passes, with clock sets that often land just
	// before a rollover so the carries reach month and year.
	function automatic item_t rand_item();
		int pick;
		int mo;
		int y;
		pick = $urandom_range(99);
		if (pick < 72) begin
			case ($urandom_range(9))
				0:       return mk_tick(0);
				1:       return mk_tick($urandom_range(127, 100));
				default: return mk_tick($urandom_range(99, 1));
			endcase
		end else if (pick < 82) begin
			case ($urandom_range(3))
				0: begin
					// raw field values, out of range included
					item_t it;
					it      = noise();
					it.func = FUNC_SET;
					return it;
				end
				1:
					return mk_set($urandom_range(99), $urandom_range(12, 1),
						$urandom_range(31, 1), $urandom_range(23), $urandom_range(59),
						$urandom_range(59));
				default: begin
					mo = ($urandom_range(3) == 0) ? 12 : $urandom_range(12, 1);
					y  = ($urandom_range(3) == 0) ? 99 : $urandom_range(99);
					return mk_set(y, mo, month_end(mo, y) - 1, 23, 59, 59);
				end
			endcase
		end else if (pick < 92) begin
			return mk_load($urandom_range(1) ? $urandom_range(65535) : $urandom_range(3));
		end
		return mk_none();
	endfunction

	// Present one transaction on the slave side, wait for the handshake and
	// queue the readout it must produce.
	task automatic send_item(input item_t it, input bit typed, input result_t want);
		result_t calc;
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= it.func;
		s_axis_tdata  <= {it.timeout_value, it.set_second, it.set_minute, it.set_hour,
			it.set_day, it.set_month, it.set_year, it.elapsed_ticks};
		do
			@(posedge clk);
		while (!s_axis_tready);
		// the predictor always runs so its state stays in step with typed rows
		predict_readout(it, calc);
		readout_q.push_back(typed ? want : calc);
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			n_errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	task automatic take_readout();
		result_t got;
		result_t want;
		got.second_event      = m_axis_tuser[0];
		got.out_second        = m_axis_tdata[5:0];
		got.out_minute        = m_axis_tdata[11:6];
		got.out_hour          = m_axis_tdata[16:12];
		got.out_day           = m_axis_tdata[21:17];
		got.out_month         = m_axis_tdata[25:22];
		got.out_year          = m_axis_tdata[32:26];
		got.timeout_left      = m_axis_tdata[48:33];
		got.passes_per_second = m_axis_tdata[64:49];
		if (readout_q.size() == 0) begin
			n_errors++;
			$display("%0t: readout with none expected, expected nothing, actual tuser=%h tdata=%h",
				$time, m_axis_tuser, m_axis_tdata);
		end else begin
			want = readout_q.pop_front();
			check_field("second_event", want.second_event, got.second_event);
			check_field("out_second", want.out_second, got.out_second);
			check_field("out_minute", want.out_minute, got.out_minute);
			check_field("out_hour", want.out_hour, got.out_hour);
			check_field("out_day", want.out_day, got.out_day);
			check_field("out_month", want.out_month, got.out_month);
			check_field("out_year", want.out_year, got.out_year);
			check_field("timeout_left", want.timeout_left, got.timeout_left);
			check_field("passes_per_second", want.passes_per_second, got.passes_per_second);
			check_field("tdata pad", 0, m_axis_tdata[71:65]);
		end
	endtask

	// Master side: check on every accepted transaction, stall at random.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			take_readout();
		m_axis_tready <= ($urandom_range(99) >= idle_pct);
	end

	initial begin
		int k;

		// Directed plan. Hundredths start at 0 and are tracked by hand so that
		// each "99 then 1" pair lands exactly one second event.
		plan[0]  = '{mk_none(), 1'b1, mk_res(0, 0, 0, 0, 1, 1, 0, 0, 0)};      // reset state
		plan[1]  = '{mk_tick(0), 1'b1, mk_res(0, 0, 0, 0, 1, 1, 0, 0, 0)};     // zero ticks
		plan[2]  = '{mk_tick(127), 1'b1, mk_res(0, 0, 0, 0, 1, 1, 0, 0, 0)};   // clamps to 99
		plan[3]  = '{mk_tick(1), 1'b1, mk_res(1, 1, 0, 0, 1, 1, 0, 0, 2)};     // first second
		plan[4]  = '{mk_load(65535), 1'b1, mk_res(0, 1, 0, 0, 1, 1, 0, 65535, 2)};
		plan[5]  = '{mk_set(99, 12, 31, 23, 59, 59), 1'b1,
			mk_res(0, 59, 59, 23, 31, 12, 99, 65535, 2)};
		plan[6]  = '{mk_tick(100), 1'b0, '0};
		plan[7]  = '{mk_tick(1), 1'b0, '0};                                    // century wrap
		plan[8]  = '{mk_set(3, 2, 28, 23, 59, 59), 1'b0, '0};                  // short February
		plan[9]  = '{mk_tick(99), 1'b0, '0};
		plan[10] = '{mk_tick(1), 1'b0, '0};
		plan[11] = '{mk_set(4, 2, 28, 23, 59, 59), 1'b0, '0};                  // leap February
		plan[12] = '{mk_tick(99), 1'b0, '0};
		plan[13] = '{mk_tick(1), 1'b0, '0};
		plan[14] = '{mk_load(1), 1'b0, '0};
		plan[15] = '{mk_set(127, 15, 31, 31, 63, 63), 1'b0, '0};               // all fields but the day too big
		plan[16] = '{mk_tick(99), 1'b0, '0};
		plan[17] = '{mk_tick(1), 1'b0, '0};                                    // timer hits zero
		plan[18] = '{mk_set(0, 0, 0, 23, 59, 59), 1'b0, '0};                   // day/month zero
		plan[19] = '{mk_tick(99), 1'b0, '0};
		plan[20] = '{mk_tick(1), 1'b0, '0};                                    // timer stays zero
		plan[21] = '{mk_set(5, 4, 30, 23, 59, 59), 1'b0, '0};                  // 30-day month
		plan[22] = '{mk_tick(99), 1'b0, '0};
		plan[23] = '{mk_tick(1), 1'b0, '0};
		plan[24] = '{mk_none(), 1'b0, '0};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_item(plan[i].it, plan[i].typed, plan[i].want);

		for (k = 0; k < RAND_ITEMS; k++) begin
			// back-to-back stretch with no hold-off on either side
			idle_pct = (k >= 500 && k < 800) ? 0 : 7;
			send_item(rand_item(), 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;
		idle_pct = 7;

		while (readout_q.size() != 0)
			@(posedge clk);
		// catch any stray readout beyond the input and state/result registers
		repeat (10) @(posedge clk);
		if (n_errors == 0)
			$display("PASS tick_clock_calendar_top");
		else
			$display("FAIL tick_clock_calendar_top");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#100000;
		$display("FAIL tick_clock_calendar_top");
		$finish;
	end

endmodule
